### design/bcd_pkg.sv
`default_nettype none

package bcd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_DEB_PRESS   = 3'd1,
    ST_PRESSED     = 3'd2,
    ST_LONG        = 3'd3,
    ST_DEB_RELEASE = 3'd4
  } state_t;

  typedef enum logic [1:0] {
    EV_SINGLE = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } event_t;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned TimeW   = 32;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_CLICK = 2'd2;

  localparam logic [CfgW-1:0] DEBOUNCE_RST     = 16'd30;
  localparam logic [CfgW-1:0] LONG_PRESS_RST   = 16'd2000;
  localparam logic [CfgW-1:0] DOUBLE_CLICK_RST = 16'd350;

endpackage

`default_nettype wire

### design/button_click_detector.sv
// A request's event is visible on the output in the cycle after acceptance,
// later only while earlier events still wait in the output queue.
// Throughput: one request per cycle while in_ready is high; set by the combinational
// state update (32-bit modular subtract and compare) and a two-entry output queue.
// in_ready drops only while both output queue entries are occupied.
// Reset (rst, synchronous): idle state, times and flags cleared, registers
// back to 30 / 2000 / 350 ms, output queue emptied.
`default_nettype none

module button_click_detector (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          pin_level,
  input  wire logic [bcd_pkg::TimeW-1:0]     now_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         click_event,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bcd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [bcd_pkg::CfgW-1:0]      cfg_data
);

  logic [bcd_pkg::CfgW-1:0] debounce_ms;
  logic [bcd_pkg::CfgW-1:0] long_press_ms;
  logic [bcd_pkg::CfgW-1:0] double_click_ms;

  bcd_pkg::state_t state, state_next;
  logic [bcd_pkg::TimeW-1:0] mark_time, mark_time_next;
  logic [bcd_pkg::TimeW-1:0] release_time, release_time_next;
  logic click_pending, click_pending_next;
  logic long_seen, long_seen_next;

  logic [bcd_pkg::TimeW-1:0] diff_mark;
  logic [bcd_pkg::TimeW-1:0] diff_rel;
  logic                      mark_deb_ok;
  logic                      mark_long_ok;
  logic                      rel_in_window;
  logic                      ev_valid;
  bcd_pkg::event_t           ev;

  logic       accept;
  logic       push;
  logic       pop;
  logic [1:0] count;
  logic [1:0] q0;
  logic [1:0] q1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= bcd_pkg::DEBOUNCE_RST;
      long_press_ms   <= bcd_pkg::LONG_PRESS_RST;
      double_click_ms <= bcd_pkg::DOUBLE_CLICK_RST;
    end else if (cfg_valid) begin
      if (cfg_index == bcd_pkg::REG_DEBOUNCE) begin
        debounce_ms <= cfg_data;
      end else if (cfg_index == bcd_pkg::REG_LONG_PRESS) begin
        long_press_ms <= cfg_data;
      end else if (cfg_index == bcd_pkg::REG_DOUBLE_CLICK) begin
        double_click_ms <= cfg_data;
      end
    end
  end

  assign diff_mark     = now_ms - mark_time;
  assign diff_rel      = now_ms - release_time;
  assign mark_deb_ok   = diff_mark >= {{(bcd_pkg::TimeW-bcd_pkg::CfgW){1'b0}}, debounce_ms};
  assign mark_long_ok  = diff_mark >= {{(bcd_pkg::TimeW-bcd_pkg::CfgW){1'b0}}, long_press_ms};
  assign rel_in_window = diff_rel <= {{(bcd_pkg::TimeW-bcd_pkg::CfgW){1'b0}}, double_click_ms};

  always_comb begin
    state_next         = state;
    mark_time_next     = mark_time;
    release_time_next  = release_time;
    click_pending_next = click_pending;
    long_seen_next     = long_seen;
    ev_valid           = 1'b0;
    ev                 = bcd_pkg::EV_SINGLE;
    unique case (state)
      bcd_pkg::ST_DEB_PRESS: begin
        if (mark_deb_ok) begin
          if (!pin_level) begin
            state_next     = bcd_pkg::ST_PRESSED;
            mark_time_next = now_ms;
          end else begin
            state_next = bcd_pkg::ST_IDLE;
          end
        end
      end
      bcd_pkg::ST_PRESSED: begin
        if (pin_level) begin
          state_next     = bcd_pkg::ST_DEB_RELEASE;
          mark_time_next = now_ms;
        end else if (mark_long_ok) begin
          state_next     = bcd_pkg::ST_LONG;
          long_seen_next = 1'b1;
          ev             = bcd_pkg::EV_LONG;
          ev_valid       = 1'b1;
        end
      end
      bcd_pkg::ST_LONG: begin
        if (pin_level) begin
          state_next     = bcd_pkg::ST_DEB_RELEASE;
          mark_time_next = now_ms;
        end
      end
      bcd_pkg::ST_DEB_RELEASE: begin
        if (mark_deb_ok) begin
          if (pin_level) begin
            state_next     = bcd_pkg::ST_IDLE;
            long_seen_next = 1'b0;
            if (!long_seen) begin
              if (!click_pending) begin
                click_pending_next = 1'b1;
                release_time_next  = now_ms;
              end else if (rel_in_window) begin
                click_pending_next = 1'b0;
                ev                 = bcd_pkg::EV_DOUBLE;
                ev_valid           = 1'b1;
              end else begin
                // late second release: report first click, re-arm
                release_time_next = now_ms;
                ev                = bcd_pkg::EV_SINGLE;
                ev_valid          = 1'b1;
              end
            end
          end else begin
            state_next = bcd_pkg::ST_PRESSED;
          end
        end
      end
      default: begin
        state_next = bcd_pkg::ST_IDLE;
        if (!pin_level) begin
          state_next     = bcd_pkg::ST_DEB_PRESS;
          mark_time_next = now_ms;
        end else if (click_pending && !rel_in_window) begin
          click_pending_next = 1'b0;
          ev                 = bcd_pkg::EV_SINGLE;
          ev_valid           = 1'b1;
        end
      end
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign accept   = in_valid && in_ready;
  assign push     = accept && ev_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bcd_pkg::ST_IDLE;
      mark_time     <= '0;
      release_time  <= '0;
      click_pending <= 1'b0;
      long_seen     <= 1'b0;
    end else if (accept) begin
      state         <= state_next;
      mark_time     <= mark_time_next;
      release_time  <= release_time_next;
      click_pending <= click_pending_next;
      long_seen     <= long_seen_next;
    end
  end

  // two-entry output queue, q0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (count == 2'd1) begin
        q0 <= ev;
      end else begin
        q0 <= q1;
        q1 <= ev;
      end
    end else if (pop) begin
      q0 <= q1;
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= ev;
      end else begin
        q1 <= ev;
      end
    end
  end

  assign out_valid   = (count != 2'd0);
  assign click_event = q0;

endmodule

`default_nettype wire

### sim/bcd_checker.sv
`timescale 1ns / 1ps

module bcd_checker
  import bcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             pin_level,
  input  logic [TimeW-1:0] now_ms,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       click_event,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]  cfg_data,
  output int               errors,
  output int               pending
);

  state_t           btn_state;
  logic [TimeW-1:0] mark_t;
  logic [TimeW-1:0] rel_t;
  logic             click_armed;
  logic             long_hit;
  logic [CfgW-1:0]  dbn_ms;
  logic [CfgW-1:0]  long_ms;
  logic [CfgW-1:0]  dbl_ms;
  event_t           clicks_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    errors++;
    $display("bcd_checker: %0t: %s", $realtime, msg);
  endtask

  task automatic step_button(input logic lvl, input logic [TimeW-1:0] now);
    logic [TimeW-1:0] since;
    logic [TimeW-1:0] gap;
    since = now - mark_t;
    gap   = now - rel_t;
    case (btn_state)
      ST_DEB_PRESS: begin
        if (since >= dbn_ms) begin
          if (!lvl) begin
            btn_state = ST_PRESSED;
            mark_t    = now;
          end else begin
            btn_state = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        if (lvl) begin
          btn_state = ST_DEB_RELEASE;
          mark_t    = now;
        end else if (since >= long_ms) begin
          btn_state = ST_LONG;
          long_hit  = 1'b1;
          clicks_due.push_back(EV_LONG);
        end
      end
      ST_LONG: begin
        if (lvl) begin
          btn_state = ST_DEB_RELEASE;
          mark_t    = now;
        end
      end
      ST_DEB_RELEASE: begin
        if (since >= dbn_ms) begin
          if (lvl) begin
            btn_state = ST_IDLE;
            if (!long_hit) begin
              if (!click_armed) begin
                click_armed = 1'b1;
                rel_t       = now;
              end else if (gap <= dbl_ms) begin
                click_armed = 1'b0;
                clicks_due.push_back(EV_DOUBLE);
              end else begin
                // late second release: report the first, rearm from this one
                rel_t = now;
                clicks_due.push_back(EV_SINGLE);
              end
            end
            long_hit = 1'b0;
          end else begin
            // bounce: back to pressed, long-press timer runs from release start
            btn_state = ST_PRESSED;
          end
        end
      end
      default: begin
        btn_state = ST_IDLE;
        if (!lvl) begin
          btn_state = ST_DEB_PRESS;
          mark_t    = now;
        end else if (click_armed && gap > dbl_ms) begin
          click_armed = 1'b0;
          clicks_due.push_back(EV_SINGLE);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      btn_state   = ST_IDLE;
      mark_t      = '0;
      rel_t       = '0;
      click_armed = 1'b0;
      long_hit    = 1'b0;
      dbn_ms      = DEBOUNCE_RST;
      long_ms     = LONG_PRESS_RST;
      dbl_ms      = DOUBLE_CLICK_RST;
      clicks_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (clicks_due.size() == 0) begin
          report($sformatf("click_event %0d with none expected", click_event));
        end else begin
          event_t want;
          want = clicks_due.pop_front();
          if (click_event !== want)
            report($sformatf("click_event %0d, expected %0d", click_event, want));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:     dbn_ms  = cfg_data;
          REG_LONG_PRESS:   long_ms = cfg_data;
          REG_DOUBLE_CLICK: dbl_ms  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        step_button(pin_level, now_ms);
    end
    pending = clicks_due.size();
  end

endmodule

### sim/tb_button_click_detector.sv
`timescale 1ns / 1ps

module tb_button_click_detector;
  import bcd_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               pin_level;
  logic [TimeW-1:0]   now_ms;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         click_event;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  int errors;
  int pending;
  int cycles;
  int sent;
  int in_gap_odds;
  bit quiet;
  int dbn;
  int lng;
  int dbl;
  logic [TimeW-1:0] tnow;

  button_click_detector dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pin_level   (pin_level),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .click_event (click_event),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  bcd_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pin_level   (pin_level),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .click_event (click_event),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_button_click_detector: errors");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      n = $urandom_range(1, 16);
      repeat (n) @(negedge clk);
    end
  end

  function automatic logic [TimeW-1:0] near(input int unsigned thr);
    case ($urandom_range(0, 5))
      0:       near = (thr > 0) ? thr - 1 : 0;
      1:       near = thr;
      2:       near = thr + 1;
      3:       near = $urandom_range(0, thr);
      4:       near = thr + $urandom_range(0, thr + 8);
      default: near = $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_sample(input logic lvl, input logic [TimeW-1:0] dt);
    @(negedge clk);
    if (!quiet && in_gap_odds > 0 && $urandom_range(0, in_gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    tnow = tnow + dt;
    in_valid  <= 1'b1;
    pin_level <= lvl;
    now_ms    <= tnow;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every expected event has come out and the block is quiet
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_cfg(input int d, input int l, input int w);
    drain();
    cfg_write(REG_DEBOUNCE, d[CfgW-1:0]);
    cfg_write(REG_LONG_PRESS, l[CfgW-1:0]);
    cfg_write(REG_DOUBLE_CLICK, w[CfgW-1:0]);
    cfg_write(REG_UNUSED, CfgW'($urandom_range(0, 65535)));
    dbn = d;
    lng = l;
    dbl = w;
  endtask

  task automatic gesture;
    int kind;
    bit bounced;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 7) == 0) tnow = $urandom;
        send_sample(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2 * dbn + 4));
      end
    end else begin
      send_sample(1'b0, near(dbl));
      if ($urandom_range(0, 3) == 0) send_sample(1'($urandom_range(0, 1)), $urandom_range(0, dbn));
      send_sample(kind == 1, near(dbn));
      if (kind >= 7) send_sample(1'b0, near(lng));
      if (kind >= 5)
        repeat ($urandom_range(0, 2)) send_sample(1'b0, $urandom_range(0, lng / 2));
      if (kind >= 7 && $urandom_range(0, 1) == 1) send_sample(1'b0, near(lng));
      send_sample(1'b1, $urandom_range(0, 20));
      bounced = ($urandom_range(0, 3) == 0);
      if (bounced) begin
        send_sample(1'b0, near(dbn));
        if ($urandom_range(0, 1) == 1) send_sample(1'b0, near(lng));
        send_sample(1'b1, $urandom_range(0, 20));
      end
      send_sample(1'b1, near(dbn));
      if ($urandom_range(0, 2) == 0) send_sample(1'b1, near(dbl));
    end
  endtask

  task automatic run_gestures(input int n);
    int stop;
    stop = sent + n;
    while (sent < stop) gesture();
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    pin_level   = 1'b1;
    now_ms      = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    quiet       = 1'b0;
    in_gap_odds = 3;
    sent        = 0;
    dbn         = int'(DEBOUNCE_RST);
    lng         = int'(LONG_PRESS_RST);
    dbl         = int'(DOUBLE_CLICK_RST);
    tnow        = 32'hFFFF_F000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings; time wraps during this part
    send_sample(1'b1, 0);
    // two clicks within the window: one double click
    send_sample(1'b0, 10);
    send_sample(1'b0, 29);
    send_sample(1'b0, 1);
    send_sample(1'b1, 100);
    send_sample(1'b1, 30);
    send_sample(1'b0, 100);
    send_sample(1'b0, 30);
    send_sample(1'b1, 50);
    send_sample(1'b1, 30);
    // long press, bounce on release, long press again from release start
    send_sample(1'b0, 500);
    send_sample(1'b0, 30);
    send_sample(1'b0, 2000);
    send_sample(1'b0, 10);
    send_sample(1'b1, 5);
    send_sample(1'b0, 30);
    send_sample(1'b0, 2000);
    send_sample(1'b1, 1);
    send_sample(1'b1, 30);
    // late second click, then idle timeout
    send_sample(1'b0, 400);
    send_sample(1'b0, 30);
    send_sample(1'b1, 10);
    send_sample(1'b1, 30);
    send_sample(1'b0, 400);
    send_sample(1'b0, 30);
    send_sample(1'b1, 10);
    send_sample(1'b1, 30);
    send_sample(1'b1, 351);

    set_cfg(0, 0, 0);
    run_gestures(200);
    set_cfg(65535, 65535, 65535);
    in_gap_odds = 0;
    run_gestures(200);

    repeat (6) begin
      set_cfg($urandom_range(0, 40), $urandom_range(0, 400), $urandom_range(0, 300));
      if ($urandom_range(0, 1) == 1) tnow = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      in_gap_odds = $urandom_range(0, 4);
      run_gestures(150);
    end

    set_cfg(int'(DEBOUNCE_RST), int'(LONG_PRESS_RST), int'(DOUBLE_CLICK_RST));
    in_gap_odds = 2;
    run_gestures(200);

    set_cfg($urandom_range(0, 20), $urandom_range(0, 200), $urandom_range(0, 150));
    quiet = 1'b1;
    run_gestures(200);

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("tb_button_click_detector: clean");
    end else begin
      $display("tb_button_click_detector: errors");
    end
    $finish;
  end

endmodule
